// File: src/pps_pkg.sv
// Package for the preemptive priority scheduler: slot table sizes, item codes,
// the task memory entry layout and the sequencer state type. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package pps_pkg;

  localparam int TASK_SLOTS   = 16;
  localparam int TABLE_DEPTH  = 16;
  localparam int ACTIVE_SLOTS = (TASK_SLOTS < TABLE_DEPTH) ? TASK_SLOTS : TABLE_DEPTH;

  localparam int SLOT_W  = 4;
  localparam int CNT_W   = 5;
  localparam int TIME_W  = 32;
  localparam int ARR_W   = 16;
  localparam int BURST_W = 16;
  localparam int PRI_W   = 8;

  localparam logic [SLOT_W-1:0] LAST_SLOT  = SLOT_W'(ACTIVE_SLOTS - 1);
  localparam logic [CNT_W-1:0]  SLOT_LIMIT = CNT_W'(ACTIVE_SLOTS);
  localparam logic [TIME_W-1:0] TIME_MAX   = '1;

  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_TICK = 1'b1;

  typedef struct packed {
    logic [ARR_W-1:0]   arrival;
    logic [BURST_W-1:0] burst;
    logic [PRI_W-1:0]   priority_val;
    logic [BURST_W-1:0] remaining;
  } task_ent_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_UPDATE,
    ST_TURN,
    ST_FINISH
  } sched_state_e;

endpackage

`default_nettype wire

// File: src/preemptive_priority_scheduler_top.sv
// Preemptive priority scheduler top level: task memory, scan sequencer and
// result register. Depends on pps_pkg.
//
// Load items write one slot of a 16-entry task memory. For tick items, every
// slot is read once through the single read port of the task memory, one
// slot per cycle, while the best ready task is tracked. The chosen task is
// then written back, the time counter advances, and turnaround and waiting
// are formed in two further steps. A per-slot pending bit, cleared at reset,
// marks slots with work left, so the memory needs no clearing pass. The
// result waits in an output register; the next item is taken as soon as the
// block is idle.
`timescale 1ns / 1ps
`default_nettype none

module preemptive_priority_scheduler_top (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         in_valid_i,
  output logic                              in_stall_o,
  input  wire logic                         operation_i,
  input  wire logic [pps_pkg::SLOT_W-1:0]   slot_i,
  input  wire logic [pps_pkg::ARR_W-1:0]    arrival_time_i,
  input  wire logic [pps_pkg::BURST_W-1:0]  burst_length_i,
  input  wire logic [pps_pkg::PRI_W-1:0]    task_priority_i,
  output logic                              out_valid_o,
  input  wire logic                         out_stall_i,
  output logic                              ran_valid_o,
  output logic [pps_pkg::SLOT_W-1:0]        ran_slot_o,
  output logic                              task_finished_o,
  output logic [pps_pkg::TIME_W-1:0]        turnaround_time_o,
  output logic [pps_pkg::TIME_W-1:0]        waiting_time_o,
  output logic [pps_pkg::TIME_W-1:0]        current_time_o,
  output logic                              all_done_o
);

  localparam logic [pps_pkg::BURST_W-1:0] BURST_ONE = pps_pkg::BURST_W'(1);

  pps_pkg::task_ent_t mem_q [pps_pkg::TABLE_DEPTH];
  pps_pkg::task_ent_t rdata_q;

  pps_pkg::sched_state_e state_q, state_d;

  logic [pps_pkg::TABLE_DEPTH-1:0] pending_q, pending_d;
  logic [pps_pkg::CNT_W-1:0]       loaded_q, loaded_d;
  logic [pps_pkg::CNT_W-1:0]       completed_q, completed_d;
  logic [pps_pkg::TIME_W-1:0]      time_q, time_next;

  logic [pps_pkg::SLOT_W-1:0]      scan_idx_q, scan_idx_d;
  logic [pps_pkg::SLOT_W-1:0]      rd_idx_q;
  logic                            rd_vld_q, rd_vld_d;

  logic                            op_q;
  logic                            best_vld_q;
  logic [pps_pkg::SLOT_W-1:0]      best_slot_q;
  logic [pps_pkg::ARR_W-1:0]       best_arr_q;
  logic [pps_pkg::BURST_W-1:0]     best_burst_q;
  logic [pps_pkg::PRI_W-1:0]       best_pri_q;
  logic [pps_pkg::BURST_W-1:0]     best_rem_q;
  logic                            fin_q;
  logic [pps_pkg::TIME_W-1:0]      tat_q;
  logic [pps_pkg::TIME_W-1:0]      wait_val;
  logic [pps_pkg::CNT_W-1:0]       pend_cnt;

  logic                            in_acc;
  logic                            load_ok;
  logic                            cand;
  logic                            better;
  logic                            finishing;
  logic                            out_free;
  logic                            out_load;

  logic                            mem_re;
  logic [pps_pkg::SLOT_W-1:0]      mem_raddr;
  logic                            mem_we;
  logic [pps_pkg::SLOT_W-1:0]      mem_waddr;
  pps_pkg::task_ent_t              mem_wdata;

  assign in_acc    = in_valid_i && !in_stall_o;
  assign load_ok   = ({1'b0, slot_i} < pps_pkg::SLOT_LIMIT);
  assign out_free  = !out_valid_o || !out_stall_i;
  assign time_next = (time_q == pps_pkg::TIME_MAX) ? time_q : time_q + 1'b1;
  assign finishing = best_vld_q && (best_rem_q == BURST_ONE);
  assign pend_cnt  = loaded_q - completed_q;

  assign cand = rd_vld_q && pending_q[rd_idx_q] &&
                ({{(pps_pkg::TIME_W-pps_pkg::ARR_W){1'b0}}, rdata_q.arrival} <= time_q);
  assign better = !best_vld_q || (rdata_q.priority_val < best_pri_q) ||
                  ((rdata_q.priority_val == best_pri_q) && (rdata_q.arrival < best_arr_q));

  assign wait_val = (tat_q >= {{(pps_pkg::TIME_W-pps_pkg::BURST_W){1'b0}}, best_burst_q}) ?
                    tat_q - {{(pps_pkg::TIME_W-pps_pkg::BURST_W){1'b0}}, best_burst_q} : '0;

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      pps_pkg::ST_IDLE: begin
        if (in_acc) begin
          state_d = (operation_i == pps_pkg::OP_TICK) ? pps_pkg::ST_SCAN : pps_pkg::ST_FINISH;
        end
      end
      pps_pkg::ST_SCAN: begin
        if (scan_idx_q == pps_pkg::LAST_SLOT) begin
          state_d = pps_pkg::ST_DRAIN;
        end
      end
      pps_pkg::ST_DRAIN:  state_d = pps_pkg::ST_UPDATE;
      pps_pkg::ST_UPDATE: state_d = pps_pkg::ST_TURN;
      pps_pkg::ST_TURN:   state_d = pps_pkg::ST_FINISH;
      pps_pkg::ST_FINISH: begin
        if (out_free) begin
          state_d = pps_pkg::ST_IDLE;
        end
      end
      default: state_d = pps_pkg::ST_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    in_stall_o  = 1'b1;
    mem_re      = 1'b0;
    mem_raddr   = scan_idx_q;
    mem_we      = 1'b0;
    mem_waddr   = slot_i;
    mem_wdata   = '{arrival: arrival_time_i, burst: burst_length_i,
                    priority_val: task_priority_i, remaining: burst_length_i};
    scan_idx_d  = scan_idx_q;
    rd_vld_d    = 1'b0;
    pending_d   = pending_q;
    loaded_d    = loaded_q;
    completed_d = completed_q;
    out_load    = 1'b0;
    unique case (state_q)
      pps_pkg::ST_IDLE: begin
        in_stall_o = 1'b0;
        scan_idx_d = '0;
        if (in_acc && (operation_i == pps_pkg::OP_LOAD) && load_ok) begin
          mem_we = 1'b1;
          pending_d[slot_i] = (burst_length_i != '0);
          if (!pending_q[slot_i] && (burst_length_i != '0)) begin
            loaded_d = loaded_q + 1'b1;
          end else if (pending_q[slot_i] && (burst_length_i == '0)) begin
            loaded_d = loaded_q - 1'b1;
          end
        end
      end
      pps_pkg::ST_SCAN: begin
        mem_re     = 1'b1;
        rd_vld_d   = 1'b1;
        scan_idx_d = scan_idx_q + 1'b1;
      end
      pps_pkg::ST_UPDATE: begin
        mem_waddr = best_slot_q;
        mem_wdata = '{arrival: best_arr_q, burst: best_burst_q,
                      priority_val: best_pri_q, remaining: best_rem_q - 1'b1};
        if (best_vld_q) begin
          mem_we = 1'b1;
          if (finishing) begin
            pending_d[best_slot_q] = 1'b0;
            completed_d = completed_q + 1'b1;
          end
        end
      end
      pps_pkg::ST_FINISH: begin
        out_load = out_free;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rdata_q <= mem_q[mem_raddr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= pps_pkg::ST_IDLE;
      pending_q   <= '0;
      loaded_q    <= '0;
      completed_q <= '0;
      time_q      <= '0;
      scan_idx_q  <= '0;
      rd_vld_q    <= 1'b0;
      best_vld_q  <= 1'b0;
      fin_q       <= 1'b0;
      out_valid_o <= 1'b0;
    end else begin
      state_q     <= state_d;
      pending_q   <= pending_d;
      loaded_q    <= loaded_d;
      completed_q <= completed_d;
      scan_idx_q  <= scan_idx_d;
      rd_vld_q    <= rd_vld_d;
      if (in_acc) begin
        best_vld_q <= 1'b0;
        fin_q      <= 1'b0;
      end else if (cand && better) begin
        best_vld_q <= 1'b1;
      end
      if (state_q == pps_pkg::ST_UPDATE) begin
        time_q <= time_next;
        fin_q  <= finishing;
      end
      if (out_load) begin
        out_valid_o <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_o <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_re) begin
      rd_idx_q <= mem_raddr;
    end
    if (in_acc) begin
      op_q        <= operation_i;
      best_slot_q <= '0;
      tat_q       <= '0;
    end else if (cand && better) begin
      best_slot_q  <= rd_idx_q;
      best_arr_q   <= rdata_q.arrival;
      best_burst_q <= rdata_q.burst;
      best_pri_q   <= rdata_q.priority_val;
      best_rem_q   <= rdata_q.remaining;
    end
    if ((state_q == pps_pkg::ST_TURN) && fin_q) begin
      tat_q <= time_q - {{(pps_pkg::TIME_W-pps_pkg::ARR_W){1'b0}}, best_arr_q};
    end
    if (out_load) begin
      ran_valid_o       <= (op_q == pps_pkg::OP_TICK) && best_vld_q;
      ran_slot_o        <= best_slot_q;
      task_finished_o   <= fin_q;
      turnaround_time_o <= fin_q ? tat_q : '0;
      waiting_time_o    <= fin_q ? wait_val : '0;
      current_time_o    <= time_q;
      all_done_o        <= (completed_q == loaded_q);
    end
  end

  a_pending_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $countones(pending_q) == int'(pend_cnt))
    else $error("pending bits disagree with load and completion counts");

  a_best_pending: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == pps_pkg::ST_UPDATE && best_vld_q) |-> pending_q[best_slot_q])
    else $error("chosen task has no work left");

  a_finish_ran: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && task_finished_o) |-> ran_valid_o)
    else $error("completion reported without a task running");

  a_time_mono: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ##1 (time_q >= $past(time_q)))
    else $error("time counter moved backward");

  a_scan_no_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == pps_pkg::ST_SCAN || state_q == pps_pkg::ST_DRAIN) |-> !mem_we)
    else $error("task memory written during scan");

endmodule

`default_nettype wire
